@@ hw/rtl/dqp_pkg.sv @@
// Package for the DNS query parser: channel payload types, status codes,
// parse phases and header/question constants. No dependencies.
`default_nettype none

package dqp_pkg;

    localparam int MAX_MESSAGE_BYTES = 512;
    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES);

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(MAX_MESSAGE_BYTES - 1);
    localparam logic [POS_W-1:0] POS_ID_HI  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_ID_LO  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_FL_HI  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_FL_LO  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_QD_HI  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_QD_LO  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(11);

    localparam logic [15:0] FLAG_QR_MASK     = 16'h8000;
    localparam logic [15:0] FLAG_OPCODE_MASK = 16'h7800;
    localparam logic [7:0]  LEN_PTR_MASK     = 8'hc0;
    localparam logic [15:0] QDCOUNT_ONE      = 16'd1;
    localparam logic [15:0] QTYPE_A          = 16'd1;
    localparam logic [15:0] QTYPE_AAAA       = 16'd28;
    localparam logic [15:0] QTYPE_ANY        = 16'd255;
    localparam logic [15:0] QCLASS_IN        = 16'd1;
    localparam logic [15:0] QCLASS_ANY       = 16'd255;
    localparam logic [8:0]  NAME_LEN_MAX     = 9'd511;
    localparam logic [5:0]  QUESTION_BYTES   = 6'd4;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_MALFORMED   = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        PH_HEADER   = 6'b000001,
        PH_LENGTH   = 6'b000010,
        PH_LABEL    = 6'b000100,
        PH_QUESTION = 6'b001000,
        PH_DONE     = 6'b010000,
        PH_ERROR    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] query_id;
        logic [3:0]  opcode;
        logic        recursion_desired;
        logic        query_type;
        logic [8:0]  name_bytes;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/dqp_byte_if.sv @@
// Byte channel into the parser: valid/ready plus one message byte.
// Depends on dqp_pkg.
`default_nettype none

interface dqp_byte_if;
    import dqp_pkg::*;

    logic       valid;
    logic       ready;
    byte_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dqp_result_if.sv @@
// Result channel out of the parser: valid/ready plus one verdict.
// Depends on dqp_pkg.
`default_nettype none

interface dqp_result_if;
    import dqp_pkg::*;

    logic    valid;
    logic    ready;
    result_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dqp_parser_core.sv @@
// Per-byte parse state and next-state logic for header, QNAME and question.
// Produces the verdict for the byte being stepped. Depends on dqp_pkg.
`default_nettype none

module dqp_parser_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  step,
    input  dqp_pkg::byte_item_t  item,
    output dqp_pkg::result_t     result
);
    import dqp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_upd;
    phase_t           phase_reg, phase_next, phase_upd;
    logic [15:0]      id_reg, id_next, id_upd;
    logic [15:0]      flags_reg, flags_next, flags_upd;
    logic [15:0]      qdcount_reg, qdcount_next, qdcount_upd;
    logic [5:0]       lrem_reg, lrem_next, lrem_upd;
    logic [8:0]       nlen_reg, nlen_next, nlen_upd;
    logic [31:0]      qf_reg, qf_next, qf_upd;
    status_t          err_reg, err_next, err_upd;

    logic [7:0]       b;
    logic [5:0]       lrem_dec;
    logic [5:0]       qcount;
    logic [31:0]      qf_shift;
    logic [8:0]       nlen_inc;

    assign b        = item.data_byte;
    assign lrem_dec = lrem_reg - 6'd1;
    assign qcount   = lrem_reg + 6'd1;
    assign qf_shift = {qf_reg[23:0], b};
    assign nlen_inc = (nlen_reg < NAME_LEN_MAX) ? nlen_reg + 9'd1 : nlen_reg;

    always_comb
    begin
        pos_upd     = pos_reg;
        phase_upd   = phase_reg;
        id_upd      = id_reg;
        flags_upd   = flags_reg;
        qdcount_upd = qdcount_reg;
        lrem_upd    = lrem_reg;
        nlen_upd    = nlen_reg;
        qf_upd      = qf_reg;
        err_upd     = err_reg;

        if (step)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    unique case (pos_reg)
                        POS_ID_HI: id_upd[15:8]      = b;
                        POS_ID_LO: id_upd[7:0]       = b;
                        POS_FL_HI: flags_upd[15:8]   = b;
                        POS_FL_LO: flags_upd[7:0]    = b;
                        POS_QD_HI: qdcount_upd[15:8] = b;
                        POS_QD_LO: qdcount_upd[7:0]  = b;
                        default: ;
                    endcase
                    if (pos_reg == POS_HDR_END)
                    begin
                        priority if ((flags_reg & FLAG_QR_MASK) != 16'd0)
                        begin
                            phase_upd = PH_ERROR;
                            err_upd   = ST_MALFORMED;
                        end
                        else if ((flags_reg & FLAG_OPCODE_MASK) != 16'd0 ||
                                 qdcount_reg != QDCOUNT_ONE)
                        begin
                            phase_upd = PH_ERROR;
                            err_upd   = ST_UNSUPPORTED;
                        end
                        else
                        begin
                            phase_upd = PH_LENGTH;
                        end
                    end
                end
                PH_LENGTH:
                begin
                    nlen_upd = nlen_inc;
                    priority if (b == 8'd0)
                    begin
                        lrem_upd  = 6'd0;
                        phase_upd = PH_QUESTION;
                    end
                    else if ((b & LEN_PTR_MASK) != 8'd0)
                    begin
                        phase_upd = PH_ERROR;
                        err_upd   = ST_UNSUPPORTED;
                    end
                    else
                    begin
                        lrem_upd  = b[5:0];
                        phase_upd = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    nlen_upd = nlen_inc;
                    lrem_upd = lrem_dec;
                    if (lrem_dec == 6'd0)
                        phase_upd = PH_LENGTH;
                end
                PH_QUESTION:
                begin
                    qf_upd   = qf_shift;
                    lrem_upd = qcount;
                    if (qcount >= QUESTION_BYTES)
                    begin
                        // ANY is answered as AAAA
                        if (qf_shift[31:16] == QTYPE_ANY)
                            qf_upd[31:16] = QTYPE_AAAA;
                        if (qf_shift[31:16] != QTYPE_ANY && qf_shift[31:16] != QTYPE_A &&
                            qf_shift[31:16] != QTYPE_AAAA)
                        begin
                            phase_upd = PH_ERROR;
                            err_upd   = ST_UNSUPPORTED;
                        end
                        else if (qf_shift[15:0] != QCLASS_IN && qf_shift[15:0] != QCLASS_ANY)
                        begin
                            phase_upd = PH_ERROR;
                            err_upd   = ST_UNSUPPORTED;
                        end
                        else
                        begin
                            phase_upd = PH_DONE;
                        end
                    end
                end
                default: ;
            endcase

            // size bound, checked only while still parsing
            if (phase_upd == PH_HEADER || phase_upd == PH_LENGTH ||
                phase_upd == PH_LABEL || phase_upd == PH_QUESTION)
            begin
                if (pos_reg == POS_LAST)
                begin
                    phase_upd = PH_ERROR;
                    err_upd   = ST_MALFORMED;
                end
                else
                begin
                    pos_upd = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        priority if (err_upd != ST_OK)
            result.status = err_upd;
        else if (phase_upd != PH_DONE)
            result.status = ST_MALFORMED;
        else
            result.status = ST_OK;
        result.query_id          = id_upd;
        result.opcode            = flags_upd[14:11];
        result.recursion_desired = flags_upd[8];
        result.query_type        = (result.status == ST_OK) && (qf_upd[31:16] == QTYPE_AAAA);
        result.name_bytes        = nlen_upd;

        // last byte closes the message: back to the start state
        if (step && item.last_byte)
        begin
            pos_next     = '0;
            phase_next   = PH_HEADER;
            id_next      = '0;
            flags_next   = '0;
            qdcount_next = '0;
            lrem_next    = '0;
            nlen_next    = '0;
            qf_next      = '0;
            err_next     = ST_OK;
        end
        else
        begin
            pos_next     = pos_upd;
            phase_next   = phase_upd;
            id_next      = id_upd;
            flags_next   = flags_upd;
            qdcount_next = qdcount_upd;
            lrem_next    = lrem_upd;
            nlen_next    = nlen_upd;
            qf_next      = qf_upd;
            err_next     = err_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= PH_HEADER;
            id_reg      <= '0;
            flags_reg   <= '0;
            qdcount_reg <= '0;
            lrem_reg    <= '0;
            nlen_reg    <= '0;
            qf_reg      <= '0;
            err_reg     <= ST_OK;
        end
        else
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            id_reg      <= id_next;
            flags_reg   <= flags_next;
            qdcount_reg <= qdcount_next;
            lrem_reg    <= lrem_next;
            nlen_reg    <= nlen_next;
            qf_reg      <= qf_next;
            err_reg     <= err_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dqp_result_reg.sv @@
// Output register for verdicts: holds one result until the sink takes it.
// Depends on dqp_pkg and dqp_result_if.
`default_nettype none

module dqp_result_reg (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               load,
    input  dqp_pkg::result_t  load_item,
    output logic              free,
    dqp_result_if.source      result_out
);
    import dqp_pkg::*;

    logic    valid_reg, valid_next;
    result_t item_reg;

    assign free = !valid_reg || result_out.ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (result_out.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= load_item;
    end

    assign result_out.valid = valid_reg;
    assign result_out.item  = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dns_query_parser.sv @@
// DNS query parser top level: input byte register, parse core, result register.
// Path: the last byte passes through the input byte register, and its verdict is then loaded into the output register.
// Throughput: one byte per cycle; the input stalls only while a finished
// result waits in the output register and the next last byte needs it.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to the start of a message.
`default_nettype none

module dns_query_parser (
    input  wire          clk,
    input  wire          rst_n,
    dqp_byte_if.sink     query_in,
    dqp_result_if.source result_out
);
    import dqp_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    byte_item_t s1_item_reg;
    logic       s1_adv;
    logic       in_xfer;
    logic       out_free;
    result_t    core_result;

    assign s1_adv         = s1_valid_reg && (!s1_item_reg.last_byte || out_free);
    assign query_in.ready = !s1_valid_reg || s1_adv;
    assign in_xfer        = query_in.valid && query_in.ready;

    always_comb
    begin
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_item_reg <= query_in.item;
    end

    dqp_parser_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_adv),
        .item   (s1_item_reg),
        .result (core_result)
    );

    dqp_result_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_adv && s1_item_reg.last_byte),
        .load_item  (core_result),
        .free       (out_free),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

@@ hw/rtl/dqp_checker.sv @@
// Port-level checks on the parser's result channel, bound to the top level.
// Depends on dqp_pkg.
`default_nettype none

module dqp_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                out_valid,
    input wire                out_ready,
    input dqp_pkg::result_t   out_item
);
    import dqp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status == ST_OK || out_item.status == ST_MALFORMED ||
                      out_item.status == ST_UNSUPPORTED)
        else $error("undefined status code");

    a_type_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.query_type |-> out_item.status == ST_OK)
        else $error("query_type set on a rejected query");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_OK |->
            out_item.opcode == 4'd0 && out_item.name_bytes != 9'd0)
        else $error("accepted query with nonzero opcode or empty name");

endmodule

bind dns_query_parser dqp_checker u_dqp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_item  (result_out.item)
);

`default_nettype wire
